// ===== rtl/core/wrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wrs_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int POSE_WORDS   = 10;

   localparam int WORD_W     = 32;
   localparam int REG_W      = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int SLOT_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int RAM_DEPTH  = QUEUE_DEPTH * POSE_WORDS;
   localparam int ADDR_W     = $clog2(RAM_DEPTH);
   localparam int WORD_IDX_W = $clog2(POSE_WORDS + 1);
   localparam int PW_IDX_W   = $clog2(POSE_WORDS);
   localparam int ITER_W     = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   localparam int VEC_W   = 33;
   localparam int DELTA_W = 33;
   localparam int CX_W    = 36;
   localparam int CZ_W    = 26;
   localparam int SUM_W   = 37;
   localparam int JSUM_W  = 36;
   localparam int HALF_W  = CX_W / 2;
   localparam int GAIN_W  = 30;
   localparam int PROD_W  = HALF_W + GAIN_W;
   localparam int WIDE_W  = PROD_W + HALF_W;
   localparam int ATAN_W  = 22;

   localparam int POSE_X       = 0;
   localparam int POSE_Y       = 1;
   localparam int POSE_HEADING = 2;
   localparam int JOINT_FIRST  = 3;

   localparam logic [GAIN_W-1:0]       INV_GAIN = 30'd652032874;
   localparam logic signed [CZ_W-1:0]  DEG180   = 26'sd11796480;
   localparam logic signed [CZ_W-1:0]  DEG90    = 26'sd5898240;
   localparam logic signed [SUM_W-1:0] WORD_MAX = 37'sd2147483647;
   localparam logic signed [SUM_W-1:0] WORD_MIN = -37'sd2147483648;

   localparam logic [ATAN_W-1:0] ATAN_DEG [32] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
      22'd234379,  22'd117304,  22'd58666,  22'd29335,
      22'd14668,   22'd7334,    22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115,
      22'd57,      22'd29,      22'd14,     22'd7,
      22'd4,       22'd2,       22'd1,      22'd0,
      22'd0,       22'd0,       22'd0,      22'd0,
      22'd0,       22'd0,       22'd0,      22'd0
   };

   typedef enum logic [1:0] {
      OP_SET_POSE = 2'd0,
      OP_ENQUEUE  = 2'd1,
      OP_TICK     = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRANS_STEP_MAX  = 3'd0,
      CSR_ROT_STEP_MAX    = 3'd1,
      CSR_JOINT_STEP_MAX  = 3'd2,
      CSR_TRANS_TOLERANCE = 3'd3,
      CSR_ROT_TOLERANCE   = 3'd4
   } csr_index_type;

   typedef enum logic {
      CM_VECTOR = 1'b0,
      CM_ROTATE = 1'b1
   } cordic_mode_type;

   typedef struct packed {
      logic            start;
      cordic_mode_type mode;
   } cordic_cmd_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_MUL_LO,
      CS_MUL_HI,
      CS_MUL_SUM,
      CS_ITER,
      CS_FINISH,
      CS_DONE
   } cordic_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_FETCH,
      ST_DIFF,
      ST_VEC_GO,
      ST_VEC_WAIT,
      ST_SELECT,
      ST_AIM,
      ST_TURN,
      ST_ROT_GO,
      ST_ROT_WAIT,
      ST_JDIFF,
      ST_JSTEP,
      ST_RETIRE,
      ST_RESPOND
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/core/wrs_channel_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface wrs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic signed [31:0] in_x;
   logic signed [31:0] in_y;
   logic signed [31:0] in_heading;
   logic signed [31:0] in_shoulder_one;
   logic signed [31:0] in_shoulder_two;
   logic signed [31:0] in_shoulder_three;
   logic signed [31:0] in_elbow_one;
   logic signed [31:0] in_elbow_two;
   logic signed [31:0] in_wrist_one;
   logic signed [31:0] in_wrist_two;

   modport source (
      output valid, operation, in_x, in_y, in_heading, in_shoulder_one, in_shoulder_two,
             in_shoulder_three, in_elbow_one, in_elbow_two, in_wrist_one, in_wrist_two,
      input  ready
   );
   modport sink (
      input  valid, operation, in_x, in_y, in_heading, in_shoulder_one, in_shoulder_two,
             in_shoulder_three, in_elbow_one, in_elbow_two, in_wrist_one, in_wrist_two,
      output ready
   );
endinterface

interface wrs_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] cur_x;
   logic signed [31:0] cur_y;
   logic signed [31:0] cur_heading;
   logic signed [31:0] cur_shoulder_one;
   logic signed [31:0] cur_shoulder_two;
   logic signed [31:0] cur_shoulder_three;
   logic signed [31:0] cur_elbow_one;
   logic signed [31:0] cur_elbow_two;
   logic signed [31:0] cur_wrist_one;
   logic signed [31:0] cur_wrist_two;
   logic        target_retired;
   logic [1:0]  status;

   modport source (
      output valid, cur_x, cur_y, cur_heading, cur_shoulder_one, cur_shoulder_two,
             cur_shoulder_three, cur_elbow_one, cur_elbow_two, cur_wrist_one, cur_wrist_two,
             target_retired, status,
      input  ready
   );
   modport sink (
      input  valid, cur_x, cur_y, cur_heading, cur_shoulder_one, cur_shoulder_two,
             cur_shoulder_three, cur_elbow_one, cur_elbow_two, cur_wrist_one, cur_wrist_two,
             target_retired, status,
      output ready
   );
endinterface
`default_nettype wire

// ===== rtl/core/wrs_queue_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wrs_queue_ram (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [wrs_pkg::ADDR_W-1:0]  wr_addr,
   input  wire logic [wrs_pkg::WORD_W-1:0]  wr_data,
   input  wire logic                        rd_en,
   input  wire logic [wrs_pkg::ADDR_W-1:0]  rd_addr,
   output logic      [wrs_pkg::WORD_W-1:0]  rd_data
);

   logic [wrs_pkg::WORD_W-1:0] mem_ff [wrs_pkg::RAM_DEPTH];
   logic [wrs_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/wrs_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wrs_cordic (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire wrs_pkg::cordic_cmd_type              cmd,
   input  wire logic signed [wrs_pkg::VEC_W-1:0]     vec_x,
   input  wire logic signed [wrs_pkg::VEC_W-1:0]     vec_y,
   input  wire logic        [wrs_pkg::REG_W-1:0]     rot_len,
   input  wire logic signed [wrs_pkg::CZ_W-1:0]      rot_theta,
   output logic                                      done,
   output logic signed      [wrs_pkg::CX_W-1:0]      res_x,
   output logic signed      [wrs_pkg::CX_W-1:0]      res_y,
   output logic signed      [wrs_pkg::CZ_W-1:0]      res_z
);

   wrs_pkg::cordic_state_type state_ff, state_in;
   wrs_pkg::cordic_mode_type  mode_ff, mode_in;
   logic                      flip_ff, flip_in;
   logic [wrs_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic signed [wrs_pkg::CX_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [wrs_pkg::CZ_W-1:0] z_ff, z_in;
   logic [wrs_pkg::PROD_W-1:0] prod_ff, prod_in, acc_ff, acc_in;

   logic signed [wrs_pkg::CX_W-1:0] xs, ys;
   logic signed [wrs_pkg::CZ_W-1:0] at;
   logic [wrs_pkg::HALF_W-1:0]      mul_src;
   logic [wrs_pkg::WIDE_W-1:0]      wide_sum;
   logic                            up;
   logic                            last_iter;

   assign last_iter = (iter_ff == wrs_pkg::ITER_W'(wrs_pkg::CORDIC_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wrs_pkg::CS_IDLE: begin
            if (cmd.start) begin
               if (cmd.mode == wrs_pkg::CM_ROTATE) begin
                  state_in = wrs_pkg::CS_MUL_LO;
               end else if (vec_x == '0 && vec_y == '0) begin
                  state_in = wrs_pkg::CS_MUL_LO;
               end else begin
                  state_in = wrs_pkg::CS_ITER;
               end
            end
         end
         wrs_pkg::CS_MUL_LO:  state_in = wrs_pkg::CS_MUL_HI;
         wrs_pkg::CS_MUL_HI:  state_in = wrs_pkg::CS_MUL_SUM;
         wrs_pkg::CS_MUL_SUM: begin
            state_in = (mode_ff == wrs_pkg::CM_ROTATE) ? wrs_pkg::CS_ITER : wrs_pkg::CS_FINISH;
         end
         wrs_pkg::CS_ITER: begin
            if (last_iter) begin
               state_in = (mode_ff == wrs_pkg::CM_VECTOR) ? wrs_pkg::CS_MUL_LO
                                                          : wrs_pkg::CS_FINISH;
            end
         end
         wrs_pkg::CS_FINISH: state_in = wrs_pkg::CS_DONE;
         wrs_pkg::CS_DONE:   state_in = wrs_pkg::CS_IDLE;
         default:            state_in = wrs_pkg::CS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done  = (state_ff == wrs_pkg::CS_DONE);
      res_x = x_ff;
      res_y = y_ff;
      res_z = z_ff;
   end

   // shared shift-add unit
   always_comb begin
      xs       = x_ff >>> iter_ff;
      ys       = y_ff >>> iter_ff;
      at       = signed'(wrs_pkg::CZ_W'(wrs_pkg::ATAN_DEG[5'(iter_ff)]));
      up       = (mode_ff == wrs_pkg::CM_VECTOR) ? (y_ff >= 0) : (z_ff < 0);
      mul_src  = (state_ff == wrs_pkg::CS_MUL_LO) ? x_ff[wrs_pkg::HALF_W-1:0]
                                                 : x_ff[wrs_pkg::CX_W-1:wrs_pkg::HALF_W];
      wide_sum = wrs_pkg::WIDE_W'(acc_ff) + {prod_ff, {wrs_pkg::HALF_W{1'b0}}};
   end

   always_comb begin
      mode_in = mode_ff;
      flip_in = flip_ff;
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      unique case (state_ff)
         wrs_pkg::CS_IDLE: begin
            iter_in = '0;
            if (cmd.start) begin
               mode_in = cmd.mode;
               if (cmd.mode == wrs_pkg::CM_ROTATE) begin
                  x_in    = wrs_pkg::CX_W'(rot_len);
                  y_in    = '0;
                  flip_in = 1'b1;
                  if (rot_theta > wrs_pkg::DEG90) begin
                     z_in = rot_theta - wrs_pkg::DEG180;
                  end else if (rot_theta < -wrs_pkg::DEG90) begin
                     z_in = rot_theta + wrs_pkg::DEG180;
                  end else begin
                     z_in    = rot_theta;
                     flip_in = 1'b0;
                  end
               end else begin
                  flip_in = 1'b0;
                  if (vec_x < 0) begin
                     x_in = -wrs_pkg::CX_W'(vec_x);
                     y_in = -wrs_pkg::CX_W'(vec_y);
                     z_in = (vec_y >= 0) ? wrs_pkg::DEG180 : -wrs_pkg::DEG180;
                  end else begin
                     x_in = wrs_pkg::CX_W'(vec_x);
                     y_in = wrs_pkg::CX_W'(vec_y);
                     z_in = '0;
                  end
               end
            end
         end
         wrs_pkg::CS_MUL_LO: begin
            prod_in = mul_src * wrs_pkg::INV_GAIN;
         end
         wrs_pkg::CS_MUL_HI: begin
            acc_in  = prod_ff;
            prod_in = mul_src * wrs_pkg::INV_GAIN;
         end
         wrs_pkg::CS_MUL_SUM: begin
            // drop the Q0.30 fraction of the gain correction
            x_in    = signed'(wide_sum[wrs_pkg::WIDE_W-1:wrs_pkg::GAIN_W]);
            iter_in = '0;
         end
         wrs_pkg::CS_ITER: begin
            if (up) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end
            iter_in = last_iter ? '0 : iter_ff + 1'b1;
         end
         wrs_pkg::CS_FINISH: begin
            if (mode_ff == wrs_pkg::CM_ROTATE && flip_ff) begin
               x_in = -x_ff;
               y_in = -y_ff;
            end
         end
         wrs_pkg::CS_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrs_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      flip_ff <= flip_in;
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/waypoint_rate_limited_stepper_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir   handshake      carries
// req_if    in    valid/ready    operation, pose in Q15.16
// rsp_if    out   valid/ready    pose after the item, target_retired, status
// csr_*     in    write enable   step limits and tolerances
//
// Set pose, full-queue enqueue, empty tick and unknown operations go straight to the
// response; an enqueue writes one queue RAM word per cycle. A tick reads the head
// target, makes a bearing pass through the shared CORDIC unit (16 iterations, the
// gain multiply in low, high and sum steps, and a finish), a heading turn when needed
// or a drive pass when the base moves, and a difference and a step for each joint.
// Reset is synchronous; the queue RAM is not cleared, as only filled slots are read.
// req_if.ready is high only while idle; a stalled response holds everything.
module waypoint_rate_limited_stepper_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   wrs_req_if.sink                              req_if,
   wrs_rsp_if.source                            rsp_if,
   input  wire logic                            csr_wr_en,
   input  wire logic [wrs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [wrs_pkg::REG_W-1:0]       csr_wr_data
);

   function automatic logic signed [wrs_pkg::WORD_W-1:0] sat_word(
      input logic signed [wrs_pkg::SUM_W-1:0] v);
      logic signed [wrs_pkg::WORD_W-1:0] r;
      if (v > wrs_pkg::WORD_MAX) begin
         r = wrs_pkg::WORD_MAX[wrs_pkg::WORD_W-1:0];
      end else if (v < wrs_pkg::WORD_MIN) begin
         r = wrs_pkg::WORD_MIN[wrs_pkg::WORD_W-1:0];
      end else begin
         r = v[wrs_pkg::WORD_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [wrs_pkg::DELTA_W-1:0] clamp_mag(
      input logic signed [wrs_pkg::DELTA_W-1:0] v,
      input logic        [wrs_pkg::REG_W-1:0]   lim);
      logic signed [wrs_pkg::DELTA_W-1:0] limv;
      logic signed [wrs_pkg::DELTA_W-1:0] r;
      limv = signed'(wrs_pkg::DELTA_W'(lim));
      if (v > limv) begin
         r = limv;
      end else if (v < -limv) begin
         r = -limv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [wrs_pkg::DELTA_W-1:0] abs_mag(
      input logic signed [wrs_pkg::DELTA_W-1:0] v);
      return v[wrs_pkg::DELTA_W-1] ? unsigned'(-v) : unsigned'(v);
   endfunction

   function automatic logic [wrs_pkg::SLOT_W-1:0] next_slot(
      input logic [wrs_pkg::SLOT_W-1:0] s);
      return (s == wrs_pkg::SLOT_W'(wrs_pkg::QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   wrs_pkg::state_type state_ff, state_in;

   logic [wrs_pkg::REG_W-1:0] trans_step_ff, rot_step_ff, joint_step_ff;
   logic [wrs_pkg::REG_W-1:0] trans_tol_ff, rot_tol_ff;

   logic [wrs_pkg::SLOT_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [wrs_pkg::COUNT_W-1:0] count_ff, count_in;

   logic signed [wrs_pkg::WORD_W-1:0] pose_ff [wrs_pkg::POSE_WORDS];
   logic signed [wrs_pkg::WORD_W-1:0] pose_in [wrs_pkg::POSE_WORDS];
   logic signed [wrs_pkg::WORD_W-1:0] tgt_ff  [wrs_pkg::POSE_WORDS];
   logic signed [wrs_pkg::WORD_W-1:0] tgt_in  [wrs_pkg::POSE_WORDS];
   logic signed [wrs_pkg::WORD_W-1:0] item_ff [wrs_pkg::POSE_WORDS];
   logic signed [wrs_pkg::WORD_W-1:0] item_in [wrs_pkg::POSE_WORDS];
   logic signed [wrs_pkg::WORD_W-1:0] req_words [wrs_pkg::POSE_WORDS];

   logic [wrs_pkg::WORD_IDX_W-1:0]       word_ff, word_in;
   logic signed [wrs_pkg::VEC_W-1:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic signed [wrs_pkg::DELTA_W-1:0]   da_ff, da_in, delta_ff, delta_in;
   logic [wrs_pkg::CX_W-1:0]             mag_ff, mag_in;
   logic signed [wrs_pkg::CZ_W-1:0]      theta_ff, theta_in;
   logic                                 far_ff, far_in;
   logic [wrs_pkg::JSUM_W-1:0]           jsum_ff, jsum_in;
   logic                                 retired_ff, retired_in;
   wrs_pkg::status_type                  status_ff, status_in;

   logic                                 req_fire;
   logic                                 queue_full, queue_empty;
   logic [wrs_pkg::PW_IDX_W-1:0]         step_idx;
   logic [wrs_pkg::REG_W-1:0]            step_lim;
   logic signed [wrs_pkg::WORD_W-1:0]    step_word;
   logic signed [wrs_pkg::WORD_W-1:0]    move_x, move_y;
   logic [wrs_pkg::REG_W-1:0]            rot_len;
   logic                                 retire_ok;

   wrs_pkg::cordic_cmd_type              cordic_cmd;
   logic                                 cordic_done;
   logic signed [wrs_pkg::CX_W-1:0]      cordic_x, cordic_y;
   logic signed [wrs_pkg::CZ_W-1:0]      cordic_z;

   logic                                 ram_wr_en, ram_rd_en;
   logic [wrs_pkg::ADDR_W-1:0]           ram_wr_addr, ram_rd_addr;
   logic [wrs_pkg::WORD_W-1:0]           ram_wr_data, ram_rd_data;

   assign req_fire    = req_if.valid && req_if.ready;
   assign queue_full  = (count_ff == wrs_pkg::COUNT_W'(wrs_pkg::QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);

   always_comb begin
      req_words[0] = req_if.in_x;
      req_words[1] = req_if.in_y;
      req_words[2] = req_if.in_heading;
      req_words[3] = req_if.in_shoulder_one;
      req_words[4] = req_if.in_shoulder_two;
      req_words[5] = req_if.in_shoulder_three;
      req_words[6] = req_if.in_elbow_one;
      req_words[7] = req_if.in_elbow_two;
      req_words[8] = req_if.in_wrist_one;
      req_words[9] = req_if.in_wrist_two;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         trans_step_ff <= 31'd2294;
         rot_step_ff   <= 31'd206438;
         joint_step_ff <= 31'd187747;
         trans_tol_ff  <= 31'd6554;
         rot_tol_ff    <= 31'd6554;
      end else if (csr_wr_en) begin
         unique case (wrs_pkg::csr_index_type'(csr_index))
            wrs_pkg::CSR_TRANS_STEP_MAX:  trans_step_ff <= csr_wr_data;
            wrs_pkg::CSR_ROT_STEP_MAX:    rot_step_ff   <= csr_wr_data;
            wrs_pkg::CSR_JOINT_STEP_MAX:  joint_step_ff <= csr_wr_data;
            wrs_pkg::CSR_TRANS_TOLERANCE: trans_tol_ff  <= csr_wr_data;
            wrs_pkg::CSR_ROT_TOLERANCE:   rot_tol_ff    <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // shared step limit for heading and joints, saturation, drive length, retire test
   always_comb begin
      step_idx  = (state_ff == wrs_pkg::ST_TURN) ? wrs_pkg::PW_IDX_W'(wrs_pkg::POSE_HEADING)
                                                 : word_ff[wrs_pkg::PW_IDX_W-1:0];
      step_lim  = (state_ff == wrs_pkg::ST_TURN) ? rot_step_ff : joint_step_ff;
      step_word = sat_word(wrs_pkg::SUM_W'(pose_ff[step_idx])
                           + wrs_pkg::SUM_W'(clamp_mag(delta_ff, step_lim)));
      move_x    = sat_word(wrs_pkg::SUM_W'(pose_ff[wrs_pkg::POSE_X])
                           + wrs_pkg::SUM_W'(cordic_x));
      move_y    = sat_word(wrs_pkg::SUM_W'(pose_ff[wrs_pkg::POSE_Y])
                           + wrs_pkg::SUM_W'(cordic_y));
      rot_len   = (mag_ff > wrs_pkg::CX_W'(trans_step_ff)) ? trans_step_ff
                                                           : mag_ff[wrs_pkg::REG_W-1:0];
      retire_ok = (jsum_ff < wrs_pkg::JSUM_W'(rot_tol_ff)) && !far_ff
                  && (abs_mag(da_ff) < wrs_pkg::DELTA_W'(rot_tol_ff));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wrs_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_if.operation)
                  wrs_pkg::OP_ENQUEUE: begin
                     state_in = queue_full ? wrs_pkg::ST_RESPOND : wrs_pkg::ST_WRITE;
                  end
                  wrs_pkg::OP_TICK: begin
                     state_in = queue_empty ? wrs_pkg::ST_RESPOND : wrs_pkg::ST_FETCH;
                  end
                  default: state_in = wrs_pkg::ST_RESPOND;
               endcase
            end
         end
         wrs_pkg::ST_WRITE: begin
            if (word_ff == wrs_pkg::WORD_IDX_W'(wrs_pkg::POSE_WORDS - 1)) begin
               state_in = wrs_pkg::ST_RESPOND;
            end
         end
         wrs_pkg::ST_FETCH: begin
            if (word_ff == wrs_pkg::WORD_IDX_W'(wrs_pkg::POSE_WORDS)) begin
               state_in = wrs_pkg::ST_DIFF;
            end
         end
         wrs_pkg::ST_DIFF:     state_in = wrs_pkg::ST_VEC_GO;
         wrs_pkg::ST_VEC_GO:   state_in = wrs_pkg::ST_VEC_WAIT;
         wrs_pkg::ST_VEC_WAIT: begin
            if (cordic_done) begin
               state_in = wrs_pkg::ST_SELECT;
            end
         end
         wrs_pkg::ST_SELECT:   state_in = wrs_pkg::ST_AIM;
         wrs_pkg::ST_AIM: begin
            if (abs_mag(delta_ff) > wrs_pkg::DELTA_W'(rot_tol_ff)) begin
               state_in = wrs_pkg::ST_TURN;
            end else if (far_ff) begin
               state_in = wrs_pkg::ST_ROT_GO;
            end else begin
               state_in = wrs_pkg::ST_JDIFF;
            end
         end
         wrs_pkg::ST_TURN:     state_in = wrs_pkg::ST_JDIFF;
         wrs_pkg::ST_ROT_GO:   state_in = wrs_pkg::ST_ROT_WAIT;
         wrs_pkg::ST_ROT_WAIT: begin
            if (cordic_done) begin
               state_in = wrs_pkg::ST_JDIFF;
            end
         end
         wrs_pkg::ST_JDIFF:    state_in = wrs_pkg::ST_JSTEP;
         wrs_pkg::ST_JSTEP: begin
            state_in = (word_ff == wrs_pkg::WORD_IDX_W'(wrs_pkg::POSE_WORDS - 1))
                       ? wrs_pkg::ST_RETIRE : wrs_pkg::ST_JDIFF;
         end
         wrs_pkg::ST_RETIRE:   state_in = wrs_pkg::ST_RESPOND;
         wrs_pkg::ST_RESPOND: begin
            if (rsp_if.ready) begin
               state_in = wrs_pkg::ST_IDLE;
            end
         end
         default: state_in = wrs_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_if.ready   = (state_ff == wrs_pkg::ST_IDLE);
      rsp_if.valid   = (state_ff == wrs_pkg::ST_RESPOND);
      cordic_cmd.start = (state_ff == wrs_pkg::ST_VEC_GO) || (state_ff == wrs_pkg::ST_ROT_GO);
      cordic_cmd.mode  = (state_ff == wrs_pkg::ST_ROT_GO) ? wrs_pkg::CM_ROTATE
                                                          : wrs_pkg::CM_VECTOR;
      ram_wr_en   = (state_ff == wrs_pkg::ST_WRITE);
      ram_wr_addr = wrs_pkg::ADDR_W'(int'(tail_ff) * wrs_pkg::POSE_WORDS + int'(word_ff));
      ram_wr_data = item_ff[word_ff[wrs_pkg::PW_IDX_W-1:0]];
      ram_rd_en   = (state_ff == wrs_pkg::ST_FETCH)
                    && (word_ff < wrs_pkg::WORD_IDX_W'(wrs_pkg::POSE_WORDS));
      ram_rd_addr = wrs_pkg::ADDR_W'(int'(head_ff) * wrs_pkg::POSE_WORDS + int'(word_ff));
   end

   // datapath
   always_comb begin
      pose_in    = pose_ff;
      tgt_in     = tgt_ff;
      item_in    = item_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      word_in    = word_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      da_in      = da_ff;
      delta_in   = delta_ff;
      mag_in     = mag_ff;
      theta_in   = theta_ff;
      far_in     = far_ff;
      jsum_in    = jsum_ff;
      retired_in = retired_ff;
      status_in  = status_ff;
      unique case (state_ff)
         wrs_pkg::ST_IDLE: begin
            word_in = '0;
            jsum_in = '0;
            if (req_fire) begin
               retired_in = 1'b0;
               status_in  = wrs_pkg::STATUS_DONE;
               item_in    = req_words;
               case (req_if.operation)
                  wrs_pkg::OP_SET_POSE: pose_in = req_words;
                  wrs_pkg::OP_ENQUEUE: begin
                     if (queue_full) begin
                        status_in = wrs_pkg::STATUS_FULL;
                     end
                  end
                  wrs_pkg::OP_TICK: begin
                     if (queue_empty) begin
                        status_in = wrs_pkg::STATUS_EMPTY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         wrs_pkg::ST_WRITE: begin
            word_in = word_ff + 1'b1;
            if (word_ff == wrs_pkg::WORD_IDX_W'(wrs_pkg::POSE_WORDS - 1)) begin
               tail_in  = next_slot(tail_ff);
               count_in = count_ff + 1'b1;
            end
         end
         wrs_pkg::ST_FETCH: begin
            word_in = word_ff + 1'b1;
            // read data arrives in the cycle after its address
            if (word_ff != '0) begin
               tgt_in[wrs_pkg::PW_IDX_W'(word_ff - 1'b1)] = ram_rd_data;
            end
         end
         wrs_pkg::ST_DIFF: begin
            dx_in   = wrs_pkg::VEC_W'(tgt_ff[wrs_pkg::POSE_X])
                      - wrs_pkg::VEC_W'(pose_ff[wrs_pkg::POSE_X]);
            dy_in   = wrs_pkg::VEC_W'(tgt_ff[wrs_pkg::POSE_Y])
                      - wrs_pkg::VEC_W'(pose_ff[wrs_pkg::POSE_Y]);
            da_in   = wrs_pkg::DELTA_W'(tgt_ff[wrs_pkg::POSE_HEADING])
                      - wrs_pkg::DELTA_W'(pose_ff[wrs_pkg::POSE_HEADING]);
            word_in = wrs_pkg::WORD_IDX_W'(wrs_pkg::JOINT_FIRST);
         end
         wrs_pkg::ST_VEC_GO: begin
         end
         wrs_pkg::ST_VEC_WAIT: begin
            if (cordic_done) begin
               mag_in   = unsigned'(cordic_x);
               theta_in = cordic_z;
            end
         end
         wrs_pkg::ST_SELECT: begin
            far_in = (mag_ff >= wrs_pkg::CX_W'(trans_tol_ff));
            if (mag_ff >= wrs_pkg::CX_W'(trans_tol_ff)) begin
               // turn toward the bearing first
               delta_in = wrs_pkg::DELTA_W'(theta_ff)
                          - wrs_pkg::DELTA_W'(pose_ff[wrs_pkg::POSE_HEADING]);
            end else begin
               delta_in = da_ff;
            end
         end
         wrs_pkg::ST_AIM: begin
         end
         wrs_pkg::ST_TURN: begin
            pose_in[wrs_pkg::POSE_HEADING] = step_word;
         end
         wrs_pkg::ST_ROT_GO: begin
         end
         wrs_pkg::ST_ROT_WAIT: begin
            if (cordic_done) begin
               pose_in[wrs_pkg::POSE_X] = move_x;
               pose_in[wrs_pkg::POSE_Y] = move_y;
            end
         end
         wrs_pkg::ST_JDIFF: begin
            delta_in = wrs_pkg::DELTA_W'(tgt_ff[word_ff[wrs_pkg::PW_IDX_W-1:0]])
                       - wrs_pkg::DELTA_W'(pose_ff[word_ff[wrs_pkg::PW_IDX_W-1:0]]);
         end
         wrs_pkg::ST_JSTEP: begin
            jsum_in = jsum_ff + wrs_pkg::JSUM_W'(abs_mag(delta_ff));
            pose_in[word_ff[wrs_pkg::PW_IDX_W-1:0]] = step_word;
            word_in = word_ff + 1'b1;
         end
         wrs_pkg::ST_RETIRE: begin
            if (retire_ok) begin
               head_in    = next_slot(head_ff);
               count_in   = count_ff - 1'b1;
               retired_in = 1'b1;
            end
         end
         wrs_pkg::ST_RESPOND: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= wrs_pkg::ST_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         retired_ff <= 1'b0;
         status_ff  <= wrs_pkg::STATUS_DONE;
         for (int i = 0; i < wrs_pkg::POSE_WORDS; i++) begin
            pose_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         retired_ff <= retired_in;
         status_ff  <= status_in;
         pose_ff    <= pose_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff   <= tgt_in;
      item_ff  <= item_in;
      word_ff  <= word_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      da_ff    <= da_in;
      delta_ff <= delta_in;
      mag_ff   <= mag_in;
      theta_ff <= theta_in;
      far_ff   <= far_in;
      jsum_ff  <= jsum_in;
   end

   always_comb begin
      rsp_if.cur_x              = pose_ff[0];
      rsp_if.cur_y              = pose_ff[1];
      rsp_if.cur_heading        = pose_ff[2];
      rsp_if.cur_shoulder_one   = pose_ff[3];
      rsp_if.cur_shoulder_two   = pose_ff[4];
      rsp_if.cur_shoulder_three = pose_ff[5];
      rsp_if.cur_elbow_one      = pose_ff[6];
      rsp_if.cur_elbow_two      = pose_ff[7];
      rsp_if.cur_wrist_one      = pose_ff[8];
      rsp_if.cur_wrist_two      = pose_ff[9];
      rsp_if.target_retired     = retired_ff;
      rsp_if.status             = status_ff;
   end

   wrs_queue_ram u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   wrs_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cordic_cmd),
      .vec_x     (dx_ff),
      .vec_y     (dy_ff),
      .rot_len   (rot_len),
      .rot_theta (theta_ff),
      .done      (cordic_done),
      .res_x     (cordic_x),
      .res_y     (cordic_y),
      .res_z     (cordic_z)
   );

endmodule
`default_nettype wire

// ===== test/waypoint_rate_limited_stepper_core_tb.sv =====
`timescale 1ns / 1ps
module waypoint_rate_limited_stepper_core_tb;
   import wrs_pkg::*;

   localparam longint CYCLE_LIMIT = 3000000;
   localparam logic [30:0] REG_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [1:0]        op;
      logic [9:0][31:0]  w;
   } pose_item_t;

   typedef struct packed {
      logic [9:0][31:0]  w;
      logic              retired;
      logic [1:0]        status;
   } pose_result_t;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0] csr_wr_data;

   wrs_req_if req_ch ();
   wrs_rsp_if rsp_ch ();

   waypoint_rate_limited_stepper_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic signed [31:0] pose_now [POSE_WORDS];
   logic signed [31:0] waypoints [QUEUE_DEPTH][POSE_WORDS];
   int unsigned wp_head, wp_tail, wp_count;
   longint trans_step, rot_step, joint_step, trans_tol, rot_tol;

   pose_result_t pending_poses [$];
   int mismatches;
   longint cycles;
   int burst_left;
   int stall_mode;

   string word_names [POSE_WORDS] = '{"cur_x", "cur_y", "cur_heading", "cur_shoulder_one",
      "cur_shoulder_two", "cur_shoulder_three", "cur_elbow_one", "cur_elbow_two",
      "cur_wrist_one", "cur_wrist_two"};

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic signed [31:0] clip_word(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint limit_mag(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint abs_val(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint gain_scale(input longint v);
      logic [63:0] prod;
      prod = 64'(v) * 64'(INV_GAIN);
      return longint'(prod >> 30);
   endfunction

   // vectoring: bearing in degrees, distance through reach
   function automatic longint bearing_to(input longint ex, input longint ey,
                                         output longint reach);
      longint x, y, z, xs, ys;
      x = ex;
      y = ey;
      z = 0;
      if (x == 0 && y == 0) begin
         reach = 0;
         return 0;
      end
      if (x < 0) begin
         z = (y >= 0) ? longint'(DEG180) : -longint'(DEG180);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z += longint'(ATAN_DEG[i]);
         end else begin
            x = x - ys; y = y + xs; z -= longint'(ATAN_DEG[i]);
         end
      end
      reach = gain_scale(x);
      return z;
   endfunction

   function automatic void drive_vector(input longint len, input longint theta,
                                        output longint ox, output longint oy);
      longint x, y, z, xs, ys;
      bit flip;
      x = gain_scale(len);
      y = 0;
      z = theta;
      flip = 1'b0;
      if (z > longint'(DEG90)) begin
         z -= longint'(DEG180); flip = 1'b1;
      end else if (z < -longint'(DEG90)) begin
         z += longint'(DEG180); flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z -= longint'(ATAN_DEG[i]);
         end else begin
            x = x + ys; y = y - xs; z += longint'(ATAN_DEG[i]);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      ox = x;
      oy = y;
   endfunction

   // one tick toward the head waypoint; returns 1 when it retires
   function automatic bit step_toward_head();
      longint dx, dy, da, reach, theta, da2, adj, mx, my, d, jsum;
      dx = longint'(waypoints[wp_head][POSE_X]) - longint'(pose_now[POSE_X]);
      dy = longint'(waypoints[wp_head][POSE_Y]) - longint'(pose_now[POSE_Y]);
      da = longint'(waypoints[wp_head][POSE_HEADING]) - longint'(pose_now[POSE_HEADING]);
      jsum = 0;
      theta = bearing_to(dx, dy, reach);
      if (reach >= trans_tol) begin
         da2 = theta - longint'(pose_now[POSE_HEADING]);
         if (abs_val(da2) > rot_tol) begin
            pose_now[POSE_HEADING] = clip_word(longint'(pose_now[POSE_HEADING])
                                               + limit_mag(da2, rot_step));
         end else begin
            adj = (reach > trans_step) ? trans_step : reach;
            drive_vector(adj, theta, mx, my);
            pose_now[POSE_X] = clip_word(longint'(pose_now[POSE_X]) + mx);
            pose_now[POSE_Y] = clip_word(longint'(pose_now[POSE_Y]) + my);
         end
      end else if (abs_val(da) > rot_tol) begin
         pose_now[POSE_HEADING] = clip_word(longint'(pose_now[POSE_HEADING])
                                            + limit_mag(da, rot_step));
      end
      for (int j = JOINT_FIRST; j < POSE_WORDS; j++) begin
         d = longint'(waypoints[wp_head][j]) - longint'(pose_now[j]);
         jsum += abs_val(d);
         pose_now[j] = clip_word(longint'(pose_now[j]) + limit_mag(d, joint_step));
      end
      if (jsum < rot_tol && reach < trans_tol && abs_val(da) < rot_tol) begin
         wp_head = (wp_head + 1) % QUEUE_DEPTH;
         wp_count--;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic pose_result_t apply_item(input pose_item_t it);
      pose_result_t r;
      r.retired = 1'b0;
      r.status = STATUS_DONE;
      case (it.op)
         OP_SET_POSE: begin
            for (int j = 0; j < POSE_WORDS; j++) pose_now[j] = it.w[j];
         end
         OP_ENQUEUE: begin
            if (wp_count >= QUEUE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               for (int j = 0; j < POSE_WORDS; j++) waypoints[wp_tail][j] = it.w[j];
               wp_tail = (wp_tail + 1) % QUEUE_DEPTH;
               wp_count++;
            end
         end
         OP_TICK: begin
            if (wp_count == 0) r.status = STATUS_EMPTY;
            else r.retired = step_toward_head();
         end
         default: ;
      endcase
      for (int j = 0; j < POSE_WORDS; j++) r.w[j] = pose_now[j];
      return r;
   endfunction

   // sender: keep valid high within a burst, idle between bursts
   task automatic send_item(input pose_item_t it);
      int gap;
      pose_result_t predicted;
      req_ch.valid <= 1'b1;
      req_ch.operation <= it.op;
      req_ch.in_x <= it.w[0];
      req_ch.in_y <= it.w[1];
      req_ch.in_heading <= it.w[2];
      req_ch.in_shoulder_one <= it.w[3];
      req_ch.in_shoulder_two <= it.w[4];
      req_ch.in_shoulder_three <= it.w[5];
      req_ch.in_elbow_one <= it.w[6];
      req_ch.in_elbow_two <= it.w[7];
      req_ch.in_wrist_one <= it.w[8];
      req_ch.in_wrist_two <= it.w[9];
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_item(it);
      pending_poses = {pending_poses, predicted};
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 15);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_pose(input logic [1:0] op, input logic [9:0][31:0] w);
      pose_item_t it;
      it.op = op;
      it.w = w;
      send_item(it);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      // hold for the tail of a tick still in flight
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [REG_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_TRANS_STEP_MAX:  trans_step = longint'(val);
         CSR_ROT_STEP_MAX:    rot_step = longint'(val);
         CSR_JOINT_STEP_MAX:  joint_step = longint'(val);
         CSR_TRANS_TOLERANCE: trans_tol = longint'(val);
         CSR_ROT_TOLERANCE:   rot_tol = longint'(val);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all_regs(input logic [REG_W-1:0] ts, input logic [REG_W-1:0] rs,
                                 input logic [REG_W-1:0] js, input logic [REG_W-1:0] tt,
                                 input logic [REG_W-1:0] rt);
      write_reg(CSR_TRANS_STEP_MAX, ts);
      write_reg(CSR_ROT_STEP_MAX, rs);
      write_reg(CSR_JOINT_STEP_MAX, js);
      write_reg(CSR_TRANS_TOLERANCE, tt);
      write_reg(CSR_ROT_TOLERANCE, rt);
   endtask

   // jump onto each waypoint and tick it away
   task automatic clear_waypoints();
      logic [9:0][31:0] w;
      while (wp_count > 0 && trans_tol > 0 && rot_tol > 0) begin
         for (int j = 0; j < POSE_WORDS; j++) w[j] = waypoints[wp_head][j];
         send_pose(OP_SET_POSE, w);
         send_pose(OP_TICK, '0);
      end
   endtask

   function automatic logic [9:0][31:0] fill_pose(input logic [31:0] v);
      logic [9:0][31:0] w;
      for (int j = 0; j < POSE_WORDS; j++) w[j] = v;
      return w;
   endfunction

   function automatic logic [9:0][31:0] random_pose(input bit wide);
      logic [9:0][31:0] w;
      for (int j = 0; j < POSE_WORDS; j++)
         w[j] = wide ? $urandom() : 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      return w;
   endfunction

   function automatic logic [9:0][31:0] near_pose(input logic [9:0][31:0] b, input int r);
      logic [9:0][31:0] w;
      for (int j = 0; j < POSE_WORDS; j++)
         w[j] = ($urandom_range(0, 3) == 0) ? b[j]
                : b[j] + 32'(int'($urandom_range(0, 2 * r)) - r);
      return w;
   endfunction

   task automatic test_directed();
      logic [9:0][31:0] w;
      send_pose(OP_SET_POSE, '0);
      send_pose(OP_TICK, '0);
      send_pose(OP_ENQUEUE, '0);
      send_pose(OP_TICK, '0);
      // zero distance, heading and joints off
      w = '0;
      w[POSE_HEADING] = 32'(90 << 16);
      w[JOINT_FIRST] = 32'(7 << 16);
      send_pose(OP_ENQUEUE, w);
      repeat (3) send_pose(OP_TICK, '0);
      send_pose(OP_SET_POSE, fill_pose(32'h8000_0000));
      send_pose(OP_ENQUEUE, fill_pose(32'h7FFF_FFFF));
      repeat (3) send_pose(OP_TICK, '0);
      send_pose(OP_SET_POSE, fill_pose(32'h7FFF_FFFF));
      send_pose(OP_ENQUEUE, fill_pose(32'h8000_0000));
      repeat (2) send_pose(OP_TICK, '0);
      send_pose(2'd3, fill_pose(32'hFFFF_FFFF));
      send_pose(OP_SET_POSE, fill_pose(32'h5555_AAAA));
      send_pose(OP_TICK, '0);
      clear_waypoints();
   endtask

   task automatic test_queue_full();
      logic [9:0][31:0] b;
      b = random_pose(1'b0);
      send_pose(OP_SET_POSE, b);
      repeat (QUEUE_DEPTH + 2) send_pose(OP_ENQUEUE, near_pose(b, 1 << 12));
      repeat (4) send_pose(OP_TICK, '0);
      clear_waypoints();
   endtask

   task automatic test_random(input int n);
      int sent, r, k, t, span;
      logic [9:0][31:0] b;
      pose_item_t it;
      sent = 0;
      while (sent < n) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            it.op = 2'($urandom_range(0, 3));
            it.w = random_pose(1'b1);
            send_item(it);
            sent++;
         end else begin
            b = random_pose($urandom_range(0, 4) == 0);
            send_pose(OP_SET_POSE, b);
            k = (r < 12) ? QUEUE_DEPTH + 1 : $urandom_range(1, 3);
            span = 1 << $urandom_range(8, 20);
            for (int i = 0; i < k; i++) send_pose(OP_ENQUEUE, near_pose(b, span));
            t = $urandom_range(2, 40);
            repeat (t) send_pose(OP_TICK, '0);
            sent += 1 + k + t;
         end
      end
   endtask

   task automatic run_phase(input logic [REG_W-1:0] ts, input logic [REG_W-1:0] rs,
                            input logic [REG_W-1:0] js, input logic [REG_W-1:0] tt,
                            input logic [REG_W-1:0] rt, input int n);
      wait_drained();
      clear_waypoints();
      wait_drained();
      write_all_regs(ts, rs, js, tt, rt);
      test_random(n);
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.operation = '0;
      req_ch.in_x = '0;
      req_ch.in_y = '0;
      req_ch.in_heading = '0;
      req_ch.in_shoulder_one = '0;
      req_ch.in_shoulder_two = '0;
      req_ch.in_shoulder_three = '0;
      req_ch.in_elbow_one = '0;
      req_ch.in_elbow_two = '0;
      req_ch.in_wrist_one = '0;
      req_ch.in_wrist_two = '0;
      for (int j = 0; j < POSE_WORDS; j++) pose_now[j] = '0;
      wp_head = 0;
      wp_tail = 0;
      wp_count = 0;
      trans_step = 2294;
      rot_step = 206438;
      joint_step = 187747;
      trans_tol = 6554;
      rot_tol = 6554;
      mismatches = 0;
      burst_left = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_queue_full();
      test_random(200);
      // let everything out before carrying on
      wait_drained();
      test_random(150);
      run_phase(31'd131072, 31'd1310720, 31'd983040, 31'd6554, 31'd65536, 350);
      run_phase(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, 300);
      run_phase(31'd1, 31'd1, 31'd1, 31'd1, 31'd1, 150);
      run_phase(REG_W'($urandom_range(1, 1 << 20)), REG_W'($urandom_range(1, 1 << 22)),
                REG_W'($urandom_range(1, 1 << 22)), REG_W'($urandom_range(1, 1 << 16)),
                REG_W'($urandom_range(1, 1 << 17)), 350);
      run_phase('0, '0, '0, '0, '0, 300);
      wait_drained();

      if (mismatches == 0) $display("waypoint_rate_limited_stepper_core regression: pass");
      else $display("waypoint_rate_limited_stepper_core regression: fail");
      $finish;
   end

   // receiver: stall the response channel in a randomly chosen pattern that changes over the run
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_mode = 0;
      end else begin
         if (cycles % 400 == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
         endcase
      end
   end

   task automatic check_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0d actual %0d", name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      pose_result_t exp_r;
      logic signed [31:0] act [POSE_WORDS];
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: result item with nothing expected");
         end else begin
            exp_r = pending_poses.pop_front();
            act[0] = rsp_ch.cur_x;
            act[1] = rsp_ch.cur_y;
            act[2] = rsp_ch.cur_heading;
            act[3] = rsp_ch.cur_shoulder_one;
            act[4] = rsp_ch.cur_shoulder_two;
            act[5] = rsp_ch.cur_shoulder_three;
            act[6] = rsp_ch.cur_elbow_one;
            act[7] = rsp_ch.cur_elbow_two;
            act[8] = rsp_ch.cur_wrist_one;
            act[9] = rsp_ch.cur_wrist_two;
            for (int j = 0; j < POSE_WORDS; j++)
               check_field(word_names[j], longint'($signed(exp_r.w[j])), longint'(act[j]));
            check_field("target_retired", exp_r.retired, rsp_ch.target_retired);
            check_field("status", exp_r.status, rsp_ch.status);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         cycles <= 0;
      end else begin
         cycles <= cycles + 1;
         if (cycles > CYCLE_LIMIT) begin
            $display("waypoint_rate_limited_stepper_core regression: fail");
            $finish;
         end
      end
   end

endmodule

// ===== sim.f =====
rtl/core/wrs_pkg.sv
rtl/core/wrs_channel_if.sv
rtl/core/wrs_queue_ram.sv
rtl/core/wrs_cordic.sv
rtl/core/waypoint_rate_limited_stepper_core.sv
test/waypoint_rate_limited_stepper_core_tb.sv
